// ===== design/pdw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the palette DAC write port: request and response types,
// operation and component codes, and the 6-bit to 8-bit component expansion.
package pdw_pkg;

    localparam int DATA_W  = 8;
    localparam int COLOR_W = 9;
    localparam int COMP_W  = 2;

    // request operation codes
    localparam logic OP_LOAD_PTR   = 1'b0;
    localparam logic OP_WRITE_BYTE = 1'b1;

    // component position inside one R,G,B triple
    localparam logic [COMP_W-1:0] COMP_RED   = 2'd0;
    localparam logic [COMP_W-1:0] COMP_GREEN = 2'd1;
    localparam logic [COMP_W-1:0] COMP_BLUE  = 2'd2;

    typedef struct packed {
        logic              op;
        logic              bank;
        logic [DATA_W-1:0] data;
    } t_req;

    typedef struct packed {
        logic [COLOR_W-1:0] color_number;
        logic [DATA_W-1:0]  red;
        logic [DATA_W-1:0]  green;
        logic [DATA_W-1:0]  blue;
    } t_rsp;

    // (c << 2) | (c >> 4), low 8 bits
    function automatic logic [DATA_W-1:0] expand_component(input logic [DATA_W-1:0] c);
        return {c[5:0], 2'b00} | {4'b0000, c[7:4]};
    endfunction

endpackage

// ===== design/palette_dac_writer.sv =====
`timescale 1ns / 1ps
// Palette DAC write port, top level: pointer registers, three component
// memories (red, green, blue) and a two-register response pipeline. Uses pdw_pkg.
//
// A write request's read bytes are registered in stage one, then expanded into
// the output register. Throughput: one request per cycle while the response path
// moves; each write request writes one component memory and reads the same entry
// of all three in that cycle. Reset: pointers clear at once; the memories then clear
// over BANKS * 2**$clog2(ENTRIES_PER_BANK) rows (512 by default), requests held off.
module palette_dac_writer
    import pdw_pkg::*;
#(
    parameter int ENTRIES_PER_BANK = 256,
    parameter int BANKS            = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int EW     = $clog2(ENTRIES_PER_BANK);
    localparam int BW     = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int DEPTH  = BANKS << EW;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = EW + 2;
    localparam int QW     = 7;
    localparam int QSTEPS = 85 / ENTRIES_PER_BANK;
    localparam logic [EW-1:0] ENTRY_MAX = EW'(ENTRIES_PER_BANK - 1);
    localparam logic [AW-1:0] ADDR_MAX  = AW'(DEPTH - 1);

    // pointer per bank, kept as entry and component position
    logic [EW-1:0]     r_ptr_entry [BANKS];
    logic [COMP_W-1:0] r_ptr_comp  [BANKS];

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic               r_s1_valid;
    logic [COLOR_W-1:0] r_s1_color;
    logic [DATA_W-1:0]  r_rd [3];

    logic r_out_valid;
    t_rsp r_out;

    logic              accept, bank_ok, do_write, do_load, s1_move;
    logic [BW-1:0]     bank_idx;
    logic [EW-1:0]     cur_entry, n_entry;
    logic [COMP_W-1:0] cur_comp, n_comp;
    logic [15:0]       div_prod;
    logic [QW-1:0]     q_mod;
    logic [COMP_W-1:0] ld_comp;
    logic [EW-1:0]     ld_entry;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [2:0]        mem_we;
    logic [CW-1:0]     color_sum;

    // handshake and request decode
    assign s1_move     = r_s1_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_clearing && (!r_s1_valid || s1_move);
    assign accept      = i_req_valid && o_req_ready;
    assign bank_ok     = (BANKS > 1) || (i_req.bank == 1'b0);
    assign do_write    = accept && bank_ok && (i_req.op == OP_WRITE_BYTE);
    assign do_load     = accept && bank_ok && (i_req.op == OP_LOAD_PTR);
    assign bank_idx    = BW'(i_req.bank);
    assign cur_entry   = r_ptr_entry[bank_idx];
    assign cur_comp    = r_ptr_comp[bank_idx];

    // split a loaded pointer: data / 3 by reciprocal, then wrap the entry into the bank
    always_comb begin
        div_prod = 16'(i_req.data) * 16'd171;
        q_mod    = div_prod[15:9];
        ld_comp  = COMP_W'(i_req.data - 8'({1'b0, q_mod} * 8'd3));
        for (int i = 0; i < QSTEPS; i++) begin
            if (int'(q_mod) >= ENTRIES_PER_BANK) begin
                q_mod = q_mod - QW'(ENTRIES_PER_BANK);
            end
        end
        ld_entry = EW'(q_mod);
    end

    // advance the pointer by one component, wrapping at the end of the bank
    always_comb begin
        if (cur_comp == COMP_BLUE) begin
            n_comp  = COMP_RED;
            n_entry = (cur_entry == ENTRY_MAX) ? '0 : cur_entry + 1'b1;
        end else begin
            n_comp  = cur_comp + 1'b1;
            n_entry = cur_entry;
        end
    end

    // update the addressed bank's pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANKS; b++) begin
                r_ptr_entry[b] <= '0;
                r_ptr_comp[b]  <= COMP_RED;
            end
        end else if (do_load) begin
            r_ptr_entry[bank_idx] <= ld_entry;
            r_ptr_comp[bank_idx]  <= ld_comp;
        end else if (do_write) begin
            r_ptr_entry[bank_idx] <= n_entry;
            r_ptr_comp[bank_idx]  <= n_comp;
        end
    end

    // sweep all memory rows to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_MAX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // memory port: clear sweep or write of the pointed component
    always_comb begin
        mem_addr  = r_clearing ? r_clr_addr : AW'({bank_idx, cur_entry});
        mem_wdata = r_clearing ? '0 : i_req.data;
        for (int g = 0; g < 3; g++) begin
            mem_we[g] = r_clearing || (do_write && (cur_comp == COMP_W'(g)));
        end
    end

    // component memories: write, and read the same row with the new byte forwarded
    for (genvar g = 0; g < 3; g++) begin : g_comp_mem
        logic [DATA_W-1:0] mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (mem_we[g]) begin
                mem[mem_addr] <= mem_wdata;
            end
            if (do_write) begin
                r_rd[g] <= mem_we[g] ? mem_wdata : mem[mem_addr];
            end
        end
    end

    // colour number of the written entry
    assign color_sum = (i_req.bank ? CW'(ENTRIES_PER_BANK) : '0) + CW'(cur_entry);

    // stage one: read data in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (do_write) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_s1_color <= COLOR_W'(color_sum);
        end
    end

    // output register: expand components, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.color_number <= r_s1_color;
            r_out.red          <= expand_component(r_rd[0]);
            r_out.green        <= expand_component(r_rd[1]);
            r_out.blue         <= expand_component(r_rd[2]);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for palette_dac_writer: drives pointer loads and component
// writes, predicts each colour response in a scoreboard class. Uses pdw_pkg.
module testbench;
    import pdw_pkg::*;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PALETTE_BANKS   = 2;
    localparam int BANK_BYTES      = PALETTE_ENTRIES * 3;

    // Track pointers and component bytes; hold predicted colour responses
    class color_scoreboard;
        t_rsp        pending_colors[$];
        logic [9:0]  comp_ptr [PALETTE_BANKS];
        logic [7:0]  comp_bytes [PALETTE_BANKS][BANK_BYTES];
        int unsigned error_count;

        function new();
            error_count = 0;
            for (int b = 0; b < PALETTE_BANKS; b++) begin
                comp_ptr[b] = '0;
                for (int i = 0; i < BANK_BYTES; i++) comp_bytes[b][i] = '0;
            end
        endfunction

        // 6-bit to 8-bit widening, low 8 bits kept
        function automatic logic [7:0] widen(input logic [7:0] c);
            logic [9:0] w;
            w = ({2'b00, c} << 2) | ({2'b00, c} >> 4);
            return w[7:0];
        endfunction

        function int pending();
            return pending_colors.size();
        endfunction

        // Apply one accepted request to the shadow palette
        function void note_request(input t_req r);
            int   ptr;
            int   entry;
            t_rsp color;
            if (r.bank >= PALETTE_BANKS) return;
            if (r.op == OP_LOAD_PTR) begin
                comp_ptr[r.bank] = 10'(int'(r.data) % BANK_BYTES);
                return;
            end
            ptr = int'(comp_ptr[r.bank]) % BANK_BYTES;
            comp_bytes[r.bank][ptr] = r.data;
            entry = ptr / 3;
            color.color_number = 9'((int'(r.bank) * PALETTE_ENTRIES + entry) & 'h1FF);
            color.red   = widen(comp_bytes[r.bank][entry * 3]);
            color.green = widen(comp_bytes[r.bank][entry * 3 + 1]);
            color.blue  = widen(comp_bytes[r.bank][entry * 3 + 2]);
            pending_colors.push_back(color);
            ptr = ptr + 1;
            if (ptr >= BANK_BYTES) ptr = 0;
            comp_ptr[r.bank] = 10'(ptr);
        endfunction

        // Compare one accepted response with the oldest prediction
        function void check_response(input t_rsp got);
            t_rsp want;
            if (pending_colors.size() == 0) begin
                $error("unexpected response: color_number %0d", got.color_number);
                error_count++;
                return;
            end
            want = pending_colors.pop_front();
            if (got.color_number !== want.color_number) begin
                $error("color_number: expected %0d, actual %0d",
                       want.color_number, got.color_number);
                error_count++;
            end
            if (got.red !== want.red) begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                error_count++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                error_count++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    int stall_left       = 0;

    color_scoreboard sb = new();

    palette_dac_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Drive response ready with random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end else if (receiver_idle_on && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 6) - 1;
            rsp_ready  <= 1'b0;
        end else begin
            rsp_ready  <= 1'b1;
        end
    end

    // Check each accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_valid && rsp_ready) sb.check_response(rsp);
    end

    // Present one request, optionally after an idle burst, and wait for acceptance
    task automatic send_request(input logic op, input logic bank, input logic [7:0] data);
        t_req r;
        r.op   = op;
        r.bank = bank;
        r.data = data;
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge i_clk); while (!req_ready);
        sb.note_request(r);
    endtask

    // Drop valid and hold until every predicted response has arrived
    task automatic hold_until_drained();
        @(negedge i_clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random mix of loads and writes on both banks
    task automatic send_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) == 0)
                send_request(OP_LOAD_PTR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else
                send_request(OP_WRITE_BYTE, 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill entry 0 of bank 0 with data extremes, then start entry 1
        send_request(OP_LOAD_PTR, 1'b0, 8'd0);
        send_request(OP_WRITE_BYTE, 1'b0, 8'd63);
        send_request(OP_WRITE_BYTE, 1'b0, 8'd0);
        send_request(OP_WRITE_BYTE, 1'b0, 8'd255);
        send_request(OP_WRITE_BYTE, 1'b0, 8'h80);
        send_request(OP_WRITE_BYTE, 1'b0, 8'h01);
        // Directed: highest loadable pointer in bank 1
        send_request(OP_LOAD_PTR, 1'b1, 8'd255);
        send_request(OP_WRITE_BYTE, 1'b1, 8'hAA);
        send_request(OP_WRITE_BYTE, 1'b1, 8'h55);
        send_request(OP_WRITE_BYTE, 1'b1, 8'hFF);
        // Directed: first entry of bank 1, mid-triple start in bank 0
        send_request(OP_LOAD_PTR, 1'b1, 8'd0);
        send_request(OP_WRITE_BYTE, 1'b1, 8'h3F);
        send_request(OP_LOAD_PTR, 1'b0, 8'd254);
        send_request(OP_WRITE_BYTE, 1'b0, 8'h10);
        send_request(OP_WRITE_BYTE, 1'b0, 8'h20);
        // Directed: rewrite entry 0 and read back the earlier bytes
        send_request(OP_LOAD_PTR, 1'b0, 8'd0);
        send_request(OP_WRITE_BYTE, 1'b0, 8'h7F);
        send_request(OP_LOAD_PTR, 1'b0, 8'd2);
        send_request(OP_WRITE_BYTE, 1'b0, 8'hC0);

        hold_until_drained();

        // Random mix with idling on both sides
        send_random_mix(300);
        hold_until_drained();

        // Sweep bank 1 past its last component to force the pointer wrap
        send_request(OP_LOAD_PTR, 1'b1, 8'($urandom_range(250, 255)));
        for (int n = 0; n < 520; n++) begin
            send_request(OP_WRITE_BYTE, 1'b1, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                send_request(OP_WRITE_BYTE, 1'b0, 8'($urandom_range(0, 255)));
        end

        // Tail at full rate, no idling
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        send_random_mix(100);

        @(negedge i_clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/pdw_pkg.sv
design/palette_dac_writer.sv
bench/testbench.sv
